// ===== design/esm_pkg.sv =====
package esm_pkg;

  localparam int DEPTH      = 10;
  localparam int TICK_BITS  = 32;
  localparam int POS_BITS   = $clog2(DEPTH);
  localparam int WIN_BITS   = $clog2(DEPTH + 1);
  localparam int WIDE_BITS  = WIN_BITS + 1;

  localparam int CUTOFF_BITS = 32;
  localparam int STEP_BITS   = 24;
  localparam int SCALE_BITS  = 48;
  localparam int SPEED_BITS  = 32;
  localparam int WINDOW_BITS = 7;
  localparam int INDEX_BITS  = 2;

  localparam int CMP_BITS = (TICK_BITS > CUTOFF_BITS) ? TICK_BITS : CUTOFF_BITS;
  localparam int ACC_BITS = ((TICK_BITS > STEP_BITS) ? TICK_BITS : STEP_BITS) + 1;
  localparam int CNT_BITS = $clog2(SCALE_BITS + 1);

  localparam logic [INDEX_BITS-1:0] REG_CUTOFF = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_STEP   = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_SCALE  = 2'd2;

  localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = CUTOFF_BITS'(1000000);
  localparam logic [STEP_BITS-1:0]   STEP_RESET   = STEP_BITS'(10000);
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = SCALE_BITS'(785398);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SHRINK,
    S_SPAN,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                 wr_en;
    logic [POS_BITS-1:0]  wr_addr;
    logic [TICK_BITS-1:0] wr_data;
    logic [POS_BITS-1:0]  rd_addr;
  } ring_req_t;

  function automatic logic [POS_BITS-1:0] slot_back(logic [POS_BITS-1:0] pos,
                                                    logic [WIN_BITS-1:0] back);
    logic [WIDE_BITS-1:0] p;
    logic [WIDE_BITS-1:0] b;
    logic [WIDE_BITS-1:0] r;
    p = WIDE_BITS'(pos);
    b = WIDE_BITS'(back);
    if (p >= b) begin
      r = p - b;
    end else begin
      r = p + WIDE_BITS'(DEPTH) - b;
    end
    return r[POS_BITS-1:0];
  endfunction

endpackage

// ===== design/encoder_edge_speed_meter_core.sv =====
// Encoder speed meter: takes one pin sample word per tick and returns one result word for each.
// The edge timestamp ring sits in a small synchronous memory that is read twice per edge.
// A sample without an edge passes through evaluation and finish; a sample with an edge also
// runs the window search, one step a cycle, and then the restoring divider for the speed,
// which is skipped when the span is zero. The finished result waits in an output
// register, so the next sample word is taken while it is still pending.
module encoder_edge_speed_meter_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              pin_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [esm_pkg::SPEED_BITS-1:0]    speed_value,
  output logic [esm_pkg::WINDOW_BITS-1:0]   window_used,
  output logic                              edge_seen,
  output logic                              stopped,
  input  logic                              cfg_wr_en,
  input  logic [esm_pkg::INDEX_BITS-1:0]    cfg_index,
  input  logic [esm_pkg::SCALE_BITS-1:0]    cfg_data
);
  import esm_pkg::*;

  state_t state;
  state_t state_next;

  logic [CUTOFF_BITS-1:0] cutoff;
  logic [STEP_BITS-1:0]   step;
  logic [SCALE_BITS-1:0]  scale;

  logic [TICK_BITS-1:0]   tick_count;
  logic                   last_level;
  logic [POS_BITS-1:0]    write_pos;
  logic [SPEED_BITS-1:0]  speed_hold;
  logic [WIN_BITS-1:0]    window_hold;

  logic                   level;
  logic                   is_edge;
  logic                   stop;
  logic [TICK_BITS-1:0]   elapsed;
  logic [ACC_BITS-1:0]    acc;
  logic [WIN_BITS-1:0]    shrink;
  logic [TICK_BITS-1:0]   span;

  ring_req_t              ring_req;
  logic [TICK_BITS-1:0]   rd_data;
  logic                   div_start;
  logic                   div_done;
  logic [SCALE_BITS-1:0]  quotient;

  logic [TICK_BITS-1:0]   elapsed_now;
  logic [TICK_BITS-1:0]   span_now;
  logic [ACC_BITS-1:0]    acc_step;
  logic                   shrink_more;
  logic [WIN_BITS-1:0]    win;
  logic                   out_free;

  esm_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (ring_req),
    .rd_data (rd_data)
  );

  esm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scale),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    elapsed_now = tick_count - rd_data;
    span_now    = tick_count - rd_data;
    acc_step    = acc + ACC_BITS'((step == '0) ? STEP_BITS'(1) : step);
    shrink_more = (shrink < WIN_BITS'(DEPTH - 1)) && (acc_step <= ACC_BITS'(elapsed));
    win         = WIN_BITS'(DEPTH) - shrink;
    out_free    = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_EVAL;
      S_EVAL:   state_next = (level != last_level) ? S_SHRINK : S_FINISH;
      S_SHRINK: if (!shrink_more) state_next = S_SPAN;
      S_SPAN:   state_next = (span_now == '0) ? S_FINISH : S_DIV;
      S_DIV:    if (div_done) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    div_start         = 1'b0;
    ring_req.wr_en    = 1'b0;
    ring_req.wr_addr  = write_pos;
    ring_req.wr_data  = tick_count;
    ring_req.rd_addr  = slot_back(write_pos, WIN_BITS'(1));
    unique case (state)
      S_IDLE:   in_ready = !rst;
      S_EVAL:   ;
      S_SHRINK: ring_req.rd_addr = slot_back(write_pos, win);
      S_SPAN:   div_start = (span_now != '0);
      S_DIV:    ;
      S_FINISH: ring_req.wr_en = out_free && is_edge;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RESET;
      step   <= STEP_RESET;
      scale  <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CUTOFF: cutoff <= cfg_data[CUTOFF_BITS-1:0];
        REG_STEP:   step   <= cfg_data[STEP_BITS-1:0];
        REG_SCALE:  scale  <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        level <= pin_level;
      end
      S_EVAL: begin
        elapsed <= elapsed_now;
        is_edge <= (level != last_level);
        stop    <= (level == last_level) &&
                   (CMP_BITS'(elapsed_now) > CMP_BITS'(cutoff));
        acc     <= '0;
        shrink  <= '0;
      end
      S_SHRINK: begin
        if (shrink_more) begin
          acc    <= acc_step;
          shrink <= shrink + 1'b1;
        end
      end
      S_SPAN: begin
        span <= span_now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      last_level  <= 1'b0;
      write_pos   <= '0;
      speed_hold  <= '0;
      window_hold <= '0;
    end else begin
      if (state == S_SPAN && span_now == '0) begin
        speed_hold <= '1;
      end
      if (state == S_DIV && div_done) begin
        speed_hold <= (quotient[SCALE_BITS-1:SPEED_BITS] != '0) ? '1 :
                      quotient[SPEED_BITS-1:0];
      end
      if (state == S_FINISH && out_free) begin
        tick_count <= tick_count + 1'b1;
        if (is_edge) begin
          last_level  <= level;
          window_hold <= win;
          write_pos   <= (write_pos == POS_BITS'(DEPTH - 1)) ? '0 : write_pos + 1'b1;
        end else if (stop) begin
          speed_hold <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      speed_value <= stop ? '0 : speed_hold;
      window_used <= WINDOW_BITS'(is_edge ? win : window_hold);
      edge_seen   <= is_edge;
      stopped     <= stop;
    end
  end

endmodule

// ===== design/esm_ring.sv =====
module esm_ring (
  input  logic                            clk,
  input  logic                            rst,
  input  esm_pkg::ring_req_t              req,
  output logic [esm_pkg::TICK_BITS-1:0]   rd_data
);
  import esm_pkg::*;

  logic [TICK_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid;
  logic [TICK_BITS-1:0] rd_word;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_word <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      rd_valid <= valid[req.rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// ===== design/esm_div.sv =====
module esm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [esm_pkg::SCALE_BITS-1:0]  dividend,
  input  logic [esm_pkg::TICK_BITS-1:0]   divisor,
  output logic                            done,
  output logic [esm_pkg::SCALE_BITS-1:0]  quotient
);
  import esm_pkg::*;

  logic                  busy;
  logic [CNT_BITS-1:0]   count;
  logic [TICK_BITS-1:0]  rem;
  logic [SCALE_BITS-1:0] quo;
  logic [TICK_BITS:0]    trial;
  logic [TICK_BITS:0]    diff;
  logic                  fits;

  always_comb begin
    trial = {rem, quo[SCALE_BITS-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[TICK_BITS-1:0] : trial[TICK_BITS-1:0];
      quo <= {quo[SCALE_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(SCALE_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== tb/sv/encoder_edge_speed_meter_core_tb.sv =====
module encoder_edge_speed_meter_core_tb;
  import esm_pkg::*;

  localparam logic [INDEX_BITS-1:0] REG_NONE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;

  typedef enum logic [1:0] {
    W_SAMPLE,
    W_REG,
    W_DRAIN
  } feed_kind_t;

  typedef struct {
    feed_kind_t             kind;
    logic                   pin;
    logic [INDEX_BITS-1:0]  index;
    logic [SCALE_BITS-1:0]  data;
  } feed_word_t;

  typedef struct packed {
    logic [SPEED_BITS-1:0]  speed;
    logic [WINDOW_BITS-1:0] window;
    logic                   crossed;
    logic                   halted;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic pin_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SPEED_BITS-1:0] speed_value;
  logic [WINDOW_BITS-1:0] window_used;
  logic edge_seen;
  logic stopped;
  logic cfg_wr_en = 1'b0;
  logic [INDEX_BITS-1:0] cfg_index = '0;
  logic [SCALE_BITS-1:0] cfg_data = '0;

  feed_word_t feed[$];
  reading_t pending_readings[$];
  int words_sent = 0;
  int words_in = 0;
  int words_out = 0;
  int fails = 0;
  int idle_cycles = 0;

  logic [CUTOFF_BITS-1:0] meter_cutoff;
  logic [STEP_BITS-1:0] meter_step;
  logic [SCALE_BITS-1:0] meter_scale;
  logic [TICK_BITS-1:0] meter_tick;
  logic meter_level;
  logic [TICK_BITS-1:0] meter_ring[DEPTH];
  int meter_pos;
  logic [SPEED_BITS-1:0] meter_speed;
  logic [WINDOW_BITS-1:0] meter_window;

  encoder_edge_speed_meter_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pin_level(pin_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .speed_value(speed_value),
    .window_used(window_used),
    .edge_seen(edge_seen),
    .stopped(stopped),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic reading_t meter_predict(logic pin);
    logic [TICK_BITS-1:0] now;
    logic [TICK_BITS-1:0] prev;
    logic [TICK_BITS-1:0] elapsed;
    logic [TICK_BITS-1:0] stride;
    logic [TICK_BITS-1:0] shrink;
    logic [TICK_BITS-1:0] oldest;
    logic [TICK_BITS-1:0] span;
    logic [SCALE_BITS-1:0] quot;
    int slot;
    int win;
    reading_t r;
    now = meter_tick;
    slot = meter_pos;
    prev = meter_ring[(slot + DEPTH - 1) % DEPTH];
    elapsed = now - prev;
    r.crossed = (pin != meter_level);
    r.halted = 1'b0;
    if (r.crossed) begin
      stride = (meter_step == '0) ? TICK_BITS'(1) : TICK_BITS'(meter_step);
      shrink = elapsed / stride;
      win = (shrink >= TICK_BITS'(DEPTH - 1)) ? 1 : DEPTH - int'(shrink);
      oldest = meter_ring[(slot + DEPTH - win) % DEPTH];
      span = now - oldest;
      if (span == '0) begin
        quot = '1;
      end else begin
        quot = meter_scale / SCALE_BITS'(span);
      end
      meter_speed = ((quot >> SPEED_BITS) != '0) ? '1 : quot[SPEED_BITS-1:0];
      meter_window = WINDOW_BITS'(win);
      meter_level = pin;
      meter_ring[slot] = now;
      meter_pos = (slot + 1) % DEPTH;
    end else if (elapsed > meter_cutoff) begin
      meter_speed = '0;
      r.halted = 1'b1;
    end
    meter_tick = now + 1'b1;
    r.speed = meter_speed;
    r.window = meter_window;
    return r;
  endfunction

  task automatic check_field(string what, logic [SPEED_BITS-1:0] want,
                             logic [SPEED_BITS-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic push_sample(logic pin);
    feed_word_t w;
    w.kind = W_SAMPLE;
    w.pin = pin;
    w.index = '0;
    w.data = '0;
    feed.push_back(w);
  endtask

  task automatic push_run(logic pin, int len);
    for (int i = 0; i < len; i++) begin
      push_sample(pin);
    end
  endtask

  task automatic push_reg(logic [INDEX_BITS-1:0] idx, logic [SCALE_BITS-1:0] data);
    feed_word_t w;
    w.kind = W_REG;
    w.pin = 1'b0;
    w.index = idx;
    w.data = data;
    feed.push_back(w);
  endtask

  task automatic push_drain();
    feed_word_t w;
    w.kind = W_DRAIN;
    w.pin = 1'b0;
    w.index = '0;
    w.data = '0;
    feed.push_back(w);
  endtask

  always @(negedge clk) begin : drive
    feed_word_t head;
    logic nxt_valid;
    logic nxt_wr;
    logic quiet;
    if (!rst) begin
      nxt_valid = in_valid && (words_in != words_sent);
      nxt_wr = 1'b0;
      quiet = (words_in == words_sent) && (pending_readings.size() == 0);
      if (!nxt_valid && feed.size() != 0) begin
        head = feed[0];
        case (head.kind)
          W_SAMPLE: begin
            if ((words_sent >= 400 && words_sent < 550) || $urandom_range(99) >= 19) begin
              void'(feed.pop_front());
              pin_level <= head.pin;
              words_sent++;
              nxt_valid = 1'b1;
            end
          end
          W_REG: begin
            if (quiet) begin
              void'(feed.pop_front());
              cfg_index <= head.index;
              cfg_data <= head.data;
              nxt_wr = 1'b1;
            end
          end
          default: begin
            if (quiet) begin
              void'(feed.pop_front());
            end
          end
        endcase
      end
      in_valid <= nxt_valid;
      cfg_wr_en <= nxt_wr;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      out_ready <= (words_out >= 400 && words_out < 550) || $urandom_range(99) >= 19;
    end
  end

  always @(posedge clk) begin : observe
    reading_t want;
    reading_t got;
    logic moved;
    if (rst) begin
      meter_cutoff = CUTOFF_RESET;
      meter_step = STEP_RESET;
      meter_scale = SCALE_RESET;
      meter_tick = '0;
      meter_level = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        meter_ring[i] = '0;
      end
      meter_pos = 0;
      meter_speed = '0;
      meter_window = '0;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_wr_en) begin
        moved = 1'b1;
        case (cfg_index)
          REG_CUTOFF: meter_cutoff = cfg_data[CUTOFF_BITS-1:0];
          REG_STEP: meter_step = cfg_data[STEP_BITS-1:0];
          REG_SCALE: meter_scale = cfg_data[SCALE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        pending_readings.push_back(meter_predict(pin_level));
        words_in++;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        words_out++;
        got.speed = speed_value;
        got.window = window_used;
        got.crossed = edge_seen;
        got.halted = stopped;
        if (pending_readings.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word: expected none, got speed %0d window %0d",
                   $time, got.speed, got.window);
        end else begin
          want = pending_readings.pop_front();
          check_field("speed_value", want.speed, got.speed);
          check_field("window_used", SPEED_BITS'(want.window), SPEED_BITS'(got.window));
          check_field("edge_seen", SPEED_BITS'(want.crossed), SPEED_BITS'(got.crossed));
          check_field("stopped", SPEED_BITS'(want.halted), SPEED_BITS'(got.halted));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_readings.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic lvl;
    int count;
    int len;
    logic [CUTOFF_BITS-1:0] cut;
    logic [STEP_BITS-1:0] stp;
    logic [SCALE_BITS-1:0] scl;

    // The first edge meets a ring of zero timestamps at tick zero, so its span is zero.
    push_run(1'b1, 1);
    push_run(1'b1, 2);
    push_run(1'b0, 1);
    push_run(1'b1, 3);
    push_run(1'b0, 2);

    push_reg(REG_SCALE, '1);
    push_reg(REG_STEP, '0);
    push_reg(REG_CUTOFF, 48'hFFFF_0000_0000);
    push_reg(REG_NONE, {16'($urandom), 32'($urandom)});
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 3);
    push_run(1'b1, 1);
    push_run(1'b0, 2);

    push_reg(REG_STEP, 48'hFFFF_FF00_0002);
    push_reg(REG_CUTOFF, 48'hFFFF_FFFF_FFFF);
    push_reg(REG_SCALE, 48'd1);
    push_run(1'b1, 2);
    push_run(1'b0, 4);
    push_run(1'b1, 1);

    lvl = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(5))
        0: cut = '0;
        1: cut = '1;
        5: cut = $urandom;
        default: cut = $urandom_range(40, 1);
      endcase
      case ($urandom_range(5))
        0: stp = '0;
        1: stp = '1;
        default: stp = $urandom_range(6, 1);
      endcase
      case ($urandom_range(5))
        0: scl = '1;
        1: scl = 48'd1;
        2: scl = SCALE_RESET;
        3: scl = $urandom_range(100000, 1000);
        default: scl = {16'($urandom), 32'($urandom)};
      endcase
      push_reg(REG_CUTOFF, {16'($urandom), cut});
      push_reg(REG_STEP, {24'($urandom), stp});
      push_reg(REG_SCALE, scl);
      if ($urandom_range(3) == 0) begin
        push_reg(REG_NONE, {16'($urandom), 32'($urandom)});
      end
      count = 0;
      while (count < 105) begin
        case ($urandom_range(9))
          7, 8: len = $urandom_range(20, 7);
          9: len = $urandom_range(70, 21);
          default: len = $urandom_range(6, 1);
        endcase
        lvl = ~lvl;
        push_run(lvl, len);
        count += len;
        if ($urandom_range(29) == 0) begin
          push_drain();
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do begin
      @(negedge clk);
    end while (feed.size() != 0 || words_in != words_sent || pending_readings.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0 && pending_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
